@@ hdl/wle_pkg.sv @@
// Shared types and constants for the WS2812 line encoder.
// No dependencies; compiled first.
`default_nettype none

package wle_pkg;

	// Input and result field widths
	localparam int unsigned COUNT_W     = 8;
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned TICK_W      = 16;
	localparam int unsigned GAP_W       = 20;
	localparam int unsigned COLOUR_BITS = 3 * CHAN_W;
	localparam int unsigned COLOUR_IDX_W = $clog2(COLOUR_BITS);

	// Default pixel length in bits, legal range 24 to 32
	localparam int unsigned BITS_PER_PIXEL_DEF = 24;

	// Configuration channel
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = GAP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIT_PERIOD = 2'd0,
		CFG_ONE_HIGH   = 2'd1,
		CFG_ZERO_HIGH  = 2'd2,
		CFG_RESET_LOW  = 2'd3
	} cfg_reg_t;

	localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 16'd89;
	localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 16'd58;
	localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 16'd29;
	localparam logic [GAP_W-1:0]  RESET_LOW_RST  = 20'd72000;

	localparam logic [COLOUR_BITS-1:0] BLACK = 24'h000000;

	typedef struct packed {
		logic [TICK_W-1:0] bit_period_ticks;
		logic [TICK_W-1:0] one_high_ticks;
		logic [TICK_W-1:0] zero_high_ticks;
		logic [GAP_W-1:0]  reset_low_ticks;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEND = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

endpackage

`default_nettype wire

@@ hdl/wle_if.sv @@
// Channel interfaces of the WS2812 line encoder: command items, results, register writes.
// Depends on wle_pkg for field widths.
`default_nettype none

interface wle_item_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [wle_pkg::COUNT_W-1:0]  led_count;
	logic                         only_last_lit;
	logic [wle_pkg::CHAN_W-1:0]   red;
	logic [wle_pkg::CHAN_W-1:0]   green;
	logic [wle_pkg::CHAN_W-1:0]   blue;

	modport source (output valid, action, led_count, only_last_lit, red, green, blue,
		input ready);
	modport sink (input valid, action, led_count, only_last_lit, red, green, blue,
		output ready);
endinterface

interface wle_result_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic rejected;
	logic frame_done;

	modport source (output valid, line_level, busy_res, rejected, frame_done, input ready);
	modport sink (input valid, line_level, busy_res, rejected, frame_done, output ready);
endinterface

interface wle_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wle_pkg::CFG_IDX_W-1:0]  index;
	logic [wle_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/wle_cfg_regs.sv @@
// Timing register file of the WS2812 line encoder.
// Depends on wle_pkg and wle_cfg_if.
`default_nettype none

module wle_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	wle_cfg_if.sink       cfg,
	output wle_pkg::cfg_t regs
);
	import wle_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bit_period_ticks <= BIT_PERIOD_RST;
			regs_q.one_high_ticks   <= ONE_HIGH_RST;
			regs_q.zero_high_ticks  <= ZERO_HIGH_RST;
			regs_q.reset_low_ticks  <= RESET_LOW_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_BIT_PERIOD: regs_q.bit_period_ticks <= cfg.data[TICK_W-1:0];
				CFG_ONE_HIGH:   regs_q.one_high_ticks   <= cfg.data[TICK_W-1:0];
				CFG_ZERO_HIGH:  regs_q.zero_high_ticks  <= cfg.data[TICK_W-1:0];
				CFG_RESET_LOW:  regs_q.reset_low_ticks  <= cfg.data[GAP_W-1:0];
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/wle_core.sv @@
// Frame sequencer and result register of the WS2812 line encoder.
// Depends on wle_pkg, wle_item_if and wle_result_if.
`default_nettype none

module wle_core #(
	parameter int unsigned BITS_PER_PIXEL = wle_pkg::BITS_PER_PIXEL_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wle_pkg::cfg_t regs,
	wle_item_if.sink      item,
	wle_result_if.source  result
);
	import wle_pkg::*;

	localparam int unsigned BIT_IDX_W = $clog2(BITS_PER_PIXEL);

	// frame state
	phase_t                  phase_q, phase_d;
	logic [TICK_W-1:0]       tick_q, tick_d;
	logic [BIT_IDX_W-1:0]    bit_q, bit_d;
	logic [COUNT_W-1:0]      pix_q, pix_d;
	logic [COLOUR_BITS-1:0]  colour_q, colour_d;
	logic                    mode_q, mode_d;
	logic [GAP_W-1:0]        gap_q, gap_d;
	logic                    done_d;

	// result register
	logic out_valid_q;
	logic line_q, busy_q, rej_q, done_q;
	logic line_d, busy_d, rej_d;

	logic                    accept;
	logic                    bit_last;
	logic [COLOUR_BITS-1:0]  word;
	logic [COLOUR_IDX_W-1:0] col_idx;
	logic                    cur_bit;
	logic [TICK_W-1:0]       high_ticks;
	logic [GAP_W-1:0]        gap_inc;

	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	assign bit_last = (bit_q == BIT_IDX_W'(BITS_PER_PIXEL - 1));
	assign word     = (mode_q && pix_q > COUNT_W'(1)) ? BLACK : colour_q;
	assign col_idx  = COLOUR_IDX_W'(COLOUR_BITS - 1) - COLOUR_IDX_W'(bit_q);
	// padding bits past the colour go out as zeros
	assign cur_bit  = (bit_q < BIT_IDX_W'(COLOUR_BITS)) ? word[col_idx] : 1'b0;
	assign high_ticks = cur_bit ? regs.one_high_ticks : regs.zero_high_ticks;
	assign gap_inc  = gap_q + GAP_W'(1);

	// next state
	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bit_d    = bit_q;
		pix_d    = pix_q;
		colour_d = colour_q;
		mode_d   = mode_q;
		gap_d    = gap_q;
		done_d   = 1'b0;
		if (item.action) begin
			if (phase_q == PH_IDLE && item.led_count != '0) begin
				colour_d = {item.green, item.red, item.blue};
				mode_d   = item.only_last_lit;
				pix_d    = item.led_count;
				tick_d   = '0;
				bit_d    = '0;
				gap_d    = '0;
				phase_d  = PH_SEND;
			end
		end else begin
			unique case (phase_q)
				PH_SEND: begin
					if (tick_q >= regs.bit_period_ticks) begin
						tick_d = '0;
						if (bit_last) begin
							bit_d = '0;
							pix_d = pix_q - COUNT_W'(1);
							if (pix_q == COUNT_W'(1)) begin
								gap_d = '0;
								if (regs.reset_low_ticks == '0) begin
									phase_d = PH_IDLE;
									done_d  = 1'b1;
								end else begin
									phase_d = PH_GAP;
								end
							end
						end else begin
							bit_d = bit_q + BIT_IDX_W'(1);
						end
					end else begin
						tick_d = tick_q + TICK_W'(1);
					end
				end
				PH_GAP: begin
					if (gap_inc >= regs.reset_low_ticks) begin
						gap_d   = '0;
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end else begin
						gap_d = gap_inc;
					end
				end
				PH_IDLE: phase_d = PH_IDLE;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// result fields
	always_comb begin
		line_d = 1'b0;
		busy_d = 1'b0;
		rej_d  = 1'b0;
		if (item.action) begin
			rej_d  = (phase_q != PH_IDLE);
			busy_d = (phase_q != PH_IDLE) || (item.led_count != '0);
		end else begin
			unique case (phase_q)
				PH_SEND: begin
					line_d = (tick_q < high_ticks);
					busy_d = 1'b1;
				end
				PH_GAP:  busy_d = 1'b1;
				PH_IDLE: busy_d = 1'b0;
				default: busy_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			bit_q    <= '0;
			pix_q    <= '0;
			colour_q <= '0;
			mode_q   <= 1'b0;
			gap_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			bit_q    <= bit_d;
			pix_q    <= pix_d;
			colour_q <= colour_d;
			mode_q   <= mode_d;
			gap_q    <= gap_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q <= line_d;
			busy_q <= busy_d;
			rej_q  <= rej_d;
			done_q <= done_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.line_level = line_q;
	assign result.busy_res   = busy_q;
	assign result.rejected   = rej_q;
	assign result.frame_done = done_q;

	a_idle_no_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> pix_q == '0)
		else $error("idle with pixels still pending");

	a_send_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEND |-> pix_q != '0 && bit_q < BIT_IDX_W'(BITS_PER_PIXEL))
		else $error("sending with no pixel or bit index out of range");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted transaction left no result");

	// with no gap the last bit tick may still be high, so the line is not checked
	a_done_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> busy_q && !rej_q)
		else $error("frame end result carries inconsistent flags");

endmodule

`default_nettype wire

@@ hdl/ws2812_line_encoder.sv @@
// Top level of the WS2812 line encoder: register file plus frame sequencer.
// Depends on wle_pkg, wle_if, wle_cfg_regs and wle_core.
`default_nettype none

// WS2812 single-wire LED line encoder. Each transaction on the item channel is
// either a tick (one timer clock of the waveform) or a start command that latches
// pixel count, GRB colour and the only-last-lit mode. Every transaction gives
// exactly one result: the line level for that tick plus busy, rejected and
// frame_done flags. The result is registered in the output register. Item ready
// is high whenever that register is empty or being drained in the same cycle, so
// with result ready held high the block runs at one item every cycle. The bit
// timing registers are written over the cfg channel, which is always ready;
// write them only with no frame running. BITS_PER_PIXEL (24 to 32) sets the bits
// sent per pixel, extra bits being zeros.

module ws2812_line_encoder #(
	parameter int unsigned BITS_PER_PIXEL = wle_pkg::BITS_PER_PIXEL_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	wle_cfg_if.sink      cfg,
	wle_item_if.sink     item,
	wle_result_if.source result
);
	import wle_pkg::*;

	cfg_t regs;

	// timing registers, read live by the sequencer
	wle_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// frame sequencer with its result register
	wle_core #(
		.BITS_PER_PIXEL (BITS_PER_PIXEL)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.item   (item),
		.result (result)
	);

endmodule

`default_nettype wire

@@ dv/tb_ws2812_line_encoder.sv @@
// Self-checking testbench for ws2812_line_encoder: drives command and tick transactions,
// predicts every result in step with the sender and compares it field by field.
// Depends on wle_pkg, wle_if and the ws2812_line_encoder RTL.

module tb_ws2812_line_encoder;
	import wle_pkg::*;

	localparam int unsigned BPP = BITS_PER_PIXEL_DEF;

	// action codes on the item channel
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic rejected;
		logic frame_done;
	} line_sample_t;

	typedef struct packed {
		logic              action;
		logic [COUNT_W-1:0] led_count;
		logic              only_last_lit;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} led_cmd_t;

	// results that can be read straight off the spec
	localparam line_sample_t SAMPLE_QUIET   = 4'b0000;
	localparam line_sample_t SAMPLE_BUSY    = 4'b0100;
	localparam line_sample_t SAMPLE_REFUSED = 4'b0110;

	// one row of the directed script: a register write or a transaction
	typedef struct {
		bit                    is_reg;
		cfg_reg_t              reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		led_cmd_t              cmd;
		bit                    typed;
		line_sample_t          want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	wle_item_if   item_ch ();
	wle_result_if result_ch ();
	wle_cfg_if    cfg_ch ();

	ws2812_line_encoder #(
		.BITS_PER_PIXEL(BPP)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.item  (item_ch),
		.result(result_ch)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Line encoder prediction: timing registers plus frame sequencer state
	// ---------------------------------------------------------------------
	logic [TICK_W-1:0]      period_ticks;
	logic [TICK_W-1:0]      one_ticks;
	logic [TICK_W-1:0]      zero_ticks;
	logic [GAP_W-1:0]       gap_len;

	phase_t                 frame_phase;
	logic [TICK_W-1:0]      bit_tick;
	logic [4:0]             bit_pos;
	logic [COUNT_W-1:0]     pixels_to_go;
	logic [COLOUR_BITS-1:0] grb_word;
	logic                   last_only;
	logic [GAP_W-1:0]       gap_ticks;

	line_sample_t expected_samples[$];

	int  mismatches      = 0;
	int  results_checked = 0;
	int  items_in        = 0;
	int  frames_ended    = 0;
	int  starts_refused  = 0;
	int  reg_writes      = 0;
	bit  source_gaps_on  = 1'b1;
	bit  calm_tail       = 1'b0;
	bit  hold_go         = 1'b0;
	logic sink_hold      = 1'b0;

	// Advance the predicted line by one transaction and return its result.
	function automatic line_sample_t encode_step(input led_cmd_t c);
		line_sample_t           s;
		logic [COLOUR_BITS-1:0] word;
		logic [COLOUR_BITS-1:0] shifted;
		logic                   bit_val;
		logic [TICK_W-1:0]      high_ticks;
		s = SAMPLE_QUIET;
		if (c.action == ACT_START) begin
			// starts take no time; a busy line refuses them
			if (frame_phase != PH_IDLE) begin
				s.busy_res = 1'b1;
				s.rejected = 1'b1;
			end else if (c.led_count != '0) begin
				grb_word     = {c.green, c.red, c.blue};
				last_only    = c.only_last_lit;
				pixels_to_go = c.led_count;
				bit_tick     = '0;
				bit_pos      = '0;
				gap_ticks    = '0;
				frame_phase  = PH_SEND;
				s.busy_res   = 1'b1;
			end
		end else if (frame_phase == PH_SEND) begin
			// earlier pixels go out black when only the last one is lit
			word    = (last_only && pixels_to_go > 1) ? BLACK : grb_word;
			shifted = word << bit_pos;
			bit_val = (bit_pos < COLOUR_BITS) ? shifted[COLOUR_BITS-1] : 1'b0;
			high_ticks   = bit_val ? one_ticks : zero_ticks;
			s.line_level = (bit_tick < high_ticks);
			s.busy_res   = 1'b1;
			if (bit_tick >= period_ticks) begin
				bit_tick = '0;
				if (int'(bit_pos) + 1 >= BPP) begin
					bit_pos      = '0;
					pixels_to_go = pixels_to_go - 1'b1;
					if (pixels_to_go == '0) begin
						gap_ticks = '0;
						// no gap: done pulses on the last bit tick
						if (gap_len == '0) begin
							frame_phase  = PH_IDLE;
							s.frame_done = 1'b1;
						end else begin
							frame_phase = PH_GAP;
						end
					end
				end else begin
					bit_pos = bit_pos + 1'b1;
				end
			end else begin
				bit_tick = bit_tick + 1'b1;
			end
		end else if (frame_phase == PH_GAP) begin
			s.busy_res = 1'b1;
			gap_ticks  = gap_ticks + 1'b1;
			if (gap_ticks >= gap_len) begin
				frame_phase  = PH_IDLE;
				gap_ticks    = '0;
				s.frame_done = 1'b1;
			end
		end
		return s;
	endfunction

	// tick transaction; the other fields carry junk the block has to ignore
	function automatic led_cmd_t tick_cmd();
		led_cmd_t c;
		c.action        = ACT_TICK;
		c.led_count     = COUNT_W'($urandom);
		c.only_last_lit = 1'($urandom);
		c.red           = CHAN_W'($urandom);
		c.green         = CHAN_W'($urandom);
		c.blue          = CHAN_W'($urandom);
		return c;
	endfunction

	// Mostly well-formed traffic: start a frame when the line is idle, then tick
	// it through; now and then a start lands mid-frame and must be refused.
	function automatic led_cmd_t random_cmd();
		led_cmd_t c;
		c = tick_cmd();
		if (frame_phase == PH_IDLE) begin
			if ($urandom_range(0, 7) != 0) begin
				c.action    = ACT_START;
				c.led_count = ($urandom_range(0, 15) == 0) ?
					COUNT_W'($urandom_range(4, 8)) : COUNT_W'($urandom_range(0, 3));
			end
		end else if ($urandom_range(0, 49) == 0) begin
			c.action = ACT_START;
		end
		return c;
	endfunction

	function automatic script_row_t cmd_row(input logic act, input int count, input logic last,
		input int r, input int g, input int b, input bit typed, input line_sample_t want);
		script_row_t row;
		row.is_reg            = 1'b0;
		row.reg_idx           = CFG_BIT_PERIOD;
		row.reg_val           = '0;
		row.cmd.action        = act;
		row.cmd.led_count     = COUNT_W'(count);
		row.cmd.only_last_lit = last;
		row.cmd.red           = CHAN_W'(r);
		row.cmd.green         = CHAN_W'(g);
		row.cmd.blue          = CHAN_W'(b);
		row.typed             = typed;
		row.want              = want;
		return row;
	endfunction

	function automatic script_row_t reg_row(input cfg_reg_t idx, input int val);
		script_row_t row;
		row         = cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b0, SAMPLE_QUIET);
		row.is_reg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = CFG_DATA_W'(val);
		return row;
	endfunction

	// Offer one transaction, with an occasional gap first; predict at acceptance.
	task automatic push_item(input led_cmd_t c, input bit typed, input line_sample_t want);
		line_sample_t s;
		if (source_gaps_on && !calm_tail && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.action        <= c.action;
		item_ch.led_count     <= c.led_count;
		item_ch.only_last_lit <= c.only_last_lit;
		item_ch.red           <= c.red;
		item_ch.green         <= c.green;
		item_ch.blue          <= c.blue;
		do @(posedge clk); while (!item_ch.ready);
		s = encode_step(c);
		expected_samples.push_back(typed ? want : s);
		items_in++;
		if (s.frame_done)
			frames_ended++;
		if (s.rejected)
			starts_refused++;
		if (items_in % 100 == 0)
			source_gaps_on = ($urandom_range(0, 2) != 0);
	endtask

	// Tick any running frame out to idle, then let every result drain.
	task automatic settle_line();
		while (frame_phase != PH_IDLE)
			push_item(tick_cmd(), 1'b0, SAMPLE_QUIET);
		item_ch.valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Timing registers are read live, so only write them with the line quiet.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		settle_line();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_BIT_PERIOD: period_ticks = val[TICK_W-1:0];
			CFG_ONE_HIGH:   one_ticks    = val[TICK_W-1:0];
			CFG_ZERO_HIGH:  zero_ticks   = val[TICK_W-1:0];
			CFG_RESET_LOW:  gap_len      = val[GAP_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			mismatches++;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Result side: random stall bursts, a long hold on request, and the check
	// ---------------------------------------------------------------------
	initial begin
		int           stall_left;
		bit           stalls_on;
		line_sample_t want;
		stall_left = 0;
		stalls_on  = 1'b1;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (expected_samples.size() == 0) begin
					$error("result transaction with no expectation pending");
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					check_field("line_level", want.line_level, result_ch.line_level);
					check_field("busy_res", want.busy_res, result_ch.busy_res);
					check_field("rejected", want.rejected, result_ch.rejected);
					check_field("frame_done", want.frame_done, result_ch.frame_done);
					results_checked++;
				end
			end
			if ($urandom_range(0, 99) == 0)
				stalls_on = ($urandom_range(0, 2) != 0);
			if (sink_hold) begin
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (stalls_on && !calm_tail && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 4);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off: the sender keeps offering, so the block backs up
	// and must stall its item input.
	initial begin
		wait (hold_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (60) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// Watchdog, sized well above the slowest legal run
	initial begin
		#150_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		script_row_t script[$];
		led_cmd_t    c;
		int          phase_no;
		int          k;

		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.action        = ACT_TICK;
		item_ch.led_count     = '0;
		item_ch.only_last_lit = 1'b0;
		item_ch.red           = '0;
		item_ch.green         = '0;
		item_ch.blue          = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = CFG_BIT_PERIOD;
		cfg_ch.data           = '0;

		// predicted state after reset
		period_ticks = BIT_PERIOD_RST;
		one_ticks    = ONE_HIGH_RST;
		zero_ticks   = ZERO_HIGH_RST;
		gap_len      = RESET_LOW_RST;
		frame_phase  = PH_IDLE;
		bit_tick     = '0;
		bit_pos      = '0;
		pixels_to_go = '0;
		grb_word     = '0;
		last_only    = 1'b0;
		gap_ticks    = '0;

		// Directed script. After reset: idle ticks and a zero-length frame, then
		// short timings for one pixel with a start refused mid-frame.
		script.push_back(cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b1, SAMPLE_QUIET));
		script.push_back(cmd_row(ACT_START, 0, 1'b1, 'hFF, 'hFF, 'hFF, 1'b1, SAMPLE_QUIET));
		script.push_back(cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b1, SAMPLE_QUIET));
		script.push_back(reg_row(CFG_BIT_PERIOD, 3));
		script.push_back(reg_row(CFG_RESET_LOW, 4));
		script.push_back(cmd_row(ACT_START, 1, 1'b0, 'hA5, 'h3C, 'h0F, 1'b1, SAMPLE_BUSY));
		script.push_back(cmd_row(ACT_START, 255, 1'b1, 0, 0, 0, 1'b1, SAMPLE_REFUSED));
		script.push_back(cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b0, SAMPLE_QUIET));
		script.push_back(cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b0, SAMPLE_QUIET));
		// shortest bit, one-time past the period, zero-time nil, no latch gap
		script.push_back(reg_row(CFG_BIT_PERIOD, 1));
		script.push_back(reg_row(CFG_ONE_HIGH, 65535));
		script.push_back(reg_row(CFG_ZERO_HIGH, 0));
		script.push_back(reg_row(CFG_RESET_LOW, 0));
		script.push_back(cmd_row(ACT_START, 2, 1'b1, 'h00, 'h80, 'h01, 1'b1, SAMPLE_BUSY));
		script.push_back(cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b0, SAMPLE_QUIET));
		script.push_back(cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b0, SAMPLE_QUIET));
		script.push_back(cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b0, SAMPLE_QUIET));
		// single pixel in last-lit mode still gets the colour, one-tick gap
		script.push_back(reg_row(CFG_RESET_LOW, 1));
		script.push_back(reg_row(CFG_BIT_PERIOD, 2));
		script.push_back(reg_row(CFG_ONE_HIGH, 1));
		script.push_back(reg_row(CFG_ZERO_HIGH, 2));
		script.push_back(cmd_row(ACT_START, 1, 1'b1, 'h7F, 'hFE, 'h80, 1'b1, SAMPLE_BUSY));
		script.push_back(cmd_row(ACT_TICK, 0, 1'b0, 0, 0, 0, 1'b0, SAMPLE_QUIET));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_reg)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				push_item(script[i].cmd, script[i].typed, script[i].want);
		end

		// Random phases, each with fresh short timings so frames stay brief
		for (phase_no = 0; phase_no < 6; phase_no++) begin
			write_reg(CFG_BIT_PERIOD, CFG_DATA_W'($urandom_range(1, 3)));
			write_reg(CFG_ONE_HIGH, CFG_DATA_W'($urandom_range(0, 6)));
			write_reg(CFG_ZERO_HIGH, CFG_DATA_W'($urandom_range(0, 6)));
			write_reg(CFG_RESET_LOW, CFG_DATA_W'($urandom_range(0, 6)));
			for (k = 0; k < 180; k++) begin
				if (phase_no == 2 && k == 100)
					hold_go = 1'b1;
				if (phase_no == 3 && k == 150) begin
					// sender goes quiet until the result side has caught up
					item_ch.valid <= 1'b0;
					while (expected_samples.size() != 0)
						@(posedge clk);
				end
				push_item(random_cmd(), 1'b0, SAMPLE_QUIET);
			end
		end

		// Longest bit and gap; a full string of 255 pixels, only the last lit,
		// is left running at the end, with no idling
		write_reg(CFG_BIT_PERIOD, CFG_DATA_W'(65535));
		write_reg(CFG_ONE_HIGH, CFG_DATA_W'(0));
		write_reg(CFG_ZERO_HIGH, CFG_DATA_W'(65535));
		write_reg(CFG_RESET_LOW, CFG_DATA_W'(1048575));
		calm_tail = 1'b1;
		c               = tick_cmd();
		c.action        = ACT_START;
		c.led_count     = COUNT_W'(255);
		c.only_last_lit = 1'b1;
		c.red           = CHAN_W'('hFF);
		c.green         = CHAN_W'('hFF);
		c.blue          = CHAN_W'('hFF);
		push_item(c, 1'b1, SAMPLE_BUSY);
		c.led_count = '0;
		push_item(c, 1'b1, SAMPLE_REFUSED);
		for (k = 0; k < 148; k++)
			push_item(random_cmd(), 1'b0, SAMPLE_QUIET);

		item_ch.valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d transactions and %0d register writes;", items_in, reg_writes);
		$display("%0d results checked, %0d frames ended, %0d starts refused.",
			results_checked, frames_ended, starts_refused);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ files.f @@
hdl/wle_pkg.sv
hdl/wle_if.sv
hdl/wle_cfg_regs.sv
hdl/wle_core.sv
hdl/ws2812_line_encoder.sv
dv/tb_ws2812_line_encoder.sv
